// File: src/sepi_pkg.sv
// Shared types and constants for the Sampson epipolar error pipeline.
// No dependencies; used by sampson_error_epipolar_core.
`default_nettype none
package sepi_pkg;

    // Coordinate and matrix entry formats
    localparam int CW   = 32;            // coordinate width, Q12.20
    localparam int FB   = 20;            // fractional bits of a coordinate
    localparam int EW   = 21;            // matrix entry width, Q3.18
    localparam int ROWW = 3 * EW;        // packed row register width

    // Intermediate widths
    localparam int PW   = EW + CW;       // entry * coordinate
    localparam int XW   = PW + 2;        // one component of E*x1 or E^T*x2
    localparam int SL   = 28;            // low split of an XW word
    localparam int SH   = XW - SL;       // high split, signed
    localparam int CHW  = CW + SH;       // coordinate * high split
    localparam int CLW  = CW + SL + 1;   // coordinate * low split
    localparam int LLW  = 2 * SL;        // low * low
    localparam int HLW  = SH + SL + 1;   // high * low
    localparam int HHW  = 2 * SH;        // high * high
    localparam int SQW  = 2 * XW - 2;    // one square, nonnegative
    localparam int CCW  = 88;            // epipolar constraint value, signed
    localparam int DW   = SQW + 2;       // denominator
    localparam int KW   = 30;            // chunk width for squaring |C|
    localparam int AW   = 3 * KW;        // |C| container
    localparam int MW   = 2 * KW;        // chunk product
    localparam int NW   = 2 * AW;        // numerator C^2
    localparam int QW   = 48;            // quotient width
    localparam int DSHW = DW + 8;        // denominator scaled by 2^8
    localparam int RW   = DSHW + 1;      // partial remainder
    localparam int SATW = NW - (QW + 8); // numerator scaled down for the range check

    localparam logic [QW-1:0] ERR_MAX = {QW{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] x1_u;
        logic signed [CW-1:0] x1_v;
        logic signed [CW-1:0] x2_u;
        logic signed [CW-1:0] x2_v;
    } item_t;

    typedef struct packed {
        logic [QW-1:0] sampson_err;
        logic          saturated;
        logic          degenerate;
    } result_t;

endpackage
`default_nettype wire

// File: src/sampson_error_epipolar_core.sv
// Sampson epipolar error core: matrix registers, product pipeline and
// a restoring divider unrolled into one stage per quotient bit. Uses sepi_pkg.
`default_nettype none
//
// Usage
//   Configuration: write the three matrix rows through cfg_valid/cfg_ready,
//   cfg_index selecting row 0, 1 or 2 and cfg_data holding three signed
//   Q3.18 entries, column 0 in the low bits. cfg_ready is always high; an
//   index past row 2 is dropped. Write only while no request is in flight.
//   Requests: a request is taken at each rising edge with start high and
//   busy low. busy stays low, so one correspondence may enter every cycle.
//   Results: result_valid strobes for exactly one cycle per request, in
//   request order, carrying the error (unsigned Q16.32), a saturation flag
//   and a degenerate flag (zero denominator, error forced to 0).
//   Pipeline: 7 stages form E*x1, E^T*x2, C, the denominator and C^2 from
//   multipliers of at most 32x32 bits, one stage runs the range check, 48
//   stages each resolve one quotient bit with a 119-bit compare and
//   subtract, and one output register closes the path. Throughput is one
//   request per cycle.
//   Reset: rst_n clears the matrix rows and all valid bits at once; no
//   result is produced for a request cut off by reset.
//   Stall: the receiver cannot hold results off, so the pipeline never stops.
//
module sampson_error_epipolar_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  sepi_pkg::item_t                      item,
    output logic                                 result_valid,
    output sepi_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sepi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sepi_pkg::ROWW-1:0]            cfg_data
);
    import sepi_pkg::*;

    // ------------------------------------------------------------------
    // Matrix rows
    // ------------------------------------------------------------------
    logic [ROWW-1:0] row_reg [3];
    logic signed [EW-1:0] m [3][3];
    logic take;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign take      = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                default:  ; // drop writes to unknown registers
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m[r][c] = row_reg[r][EW*c +: EW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits for stages 1..7
    // ------------------------------------------------------------------
    logic [6:0] sv_reg;
    logic [6:0] sv_next;

    assign sv_next = {sv_reg[5:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
        end
        else
        begin
            sv_reg <= sv_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: entry * coordinate products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s1_a_reg [3][2];   // E*x1 terms of rows 0..2
    logic signed [EW-1:0] s1_am_reg [3];     // entries that meet the homogeneous 1
    logic signed [PW-1:0] s1_b_reg [2][2];   // E^T*x2 terms of columns 0..1
    logic signed [EW-1:0] s1_bm_reg [2];
    logic signed [CW-1:0] s1_u2_reg;
    logic signed [CW-1:0] s1_v2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_a_reg[i][0] <= m[i][0] * item.x1_u;
            s1_a_reg[i][1] <= m[i][1] * item.x1_v;
            s1_am_reg[i]   <= m[i][2];
        end
        for (int i = 0; i < 2; i++)
        begin
            s1_b_reg[i][0] <= m[0][i] * item.x2_u;
            s1_b_reg[i][1] <= m[1][i] * item.x2_v;
            s1_bm_reg[i]   <= m[2][i];
        end
        s1_u2_reg <= item.x2_u;
        s1_v2_reg <= item.x2_v;
    end

    // ------------------------------------------------------------------
    // Stage 2: E*x1 and the first two components of E^T*x2
    // ------------------------------------------------------------------
    logic signed [XW-1:0] s2_ex_reg [3];
    logic signed [XW-1:0] s2_et_reg [2];
    logic signed [CW-1:0] s2_u2_reg;
    logic signed [CW-1:0] s2_v2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_ex_reg[i] <= XW'(s1_a_reg[i][0]) + XW'(s1_a_reg[i][1])
                          + (XW'(s1_am_reg[i]) <<< FB);
        end
        for (int i = 0; i < 2; i++)
        begin
            s2_et_reg[i] <= XW'(s1_b_reg[i][0]) + XW'(s1_b_reg[i][1])
                          + (XW'(s1_bm_reg[i]) <<< FB);
        end
        s2_u2_reg <= s1_u2_reg;
        s2_v2_reg <= s1_v2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: split partial products for C and the four squares
    // ------------------------------------------------------------------
    logic [XW-1:0]        sq_src [4];
    logic signed [CHW-1:0] s3_uh_reg, s3_vh_reg;
    logic signed [CLW-1:0] s3_ul_reg, s3_vl_reg;
    logic signed [XW-1:0]  s3_ex2_reg;
    logic [LLW-1:0]        s3_ll_reg [4];
    logic signed [HLW-1:0] s3_hl_reg [4];
    logic signed [HHW-1:0] s3_hh_reg [4];

    assign sq_src[0] = s2_ex_reg[0];
    assign sq_src[1] = s2_ex_reg[1];
    assign sq_src[2] = s2_et_reg[0];
    assign sq_src[3] = s2_et_reg[1];

    always_ff @(posedge clk)
    begin
        s3_uh_reg  <= s2_u2_reg * $signed(s2_ex_reg[0][XW-1:SL]);
        s3_ul_reg  <= s2_u2_reg * $signed({1'b0, s2_ex_reg[0][SL-1:0]});
        s3_vh_reg  <= s2_v2_reg * $signed(s2_ex_reg[1][XW-1:SL]);
        s3_vl_reg  <= s2_v2_reg * $signed({1'b0, s2_ex_reg[1][SL-1:0]});
        s3_ex2_reg <= s2_ex_reg[2];
        for (int j = 0; j < 4; j++)
        begin
            s3_ll_reg[j] <= sq_src[j][SL-1:0] * sq_src[j][SL-1:0];
            s3_hl_reg[j] <= $signed(sq_src[j][XW-1:SL]) * $signed({1'b0, sq_src[j][SL-1:0]});
            s3_hh_reg[j] <= $signed(sq_src[j][XW-1:SL]) * $signed(sq_src[j][XW-1:SL]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: C = x2^T E x1 and the four squares
    // ------------------------------------------------------------------
    logic signed [CCW-1:0] s4_c_reg;
    logic [SQW-1:0]        s4_sq_reg [4];

    always_ff @(posedge clk)
    begin
        s4_c_reg <= (CCW'(s3_uh_reg) <<< SL) + CCW'(s3_ul_reg)
                  + (CCW'(s3_vh_reg) <<< SL) + CCW'(s3_vl_reg)
                  + (CCW'(s3_ex2_reg) <<< FB);
        for (int j = 0; j < 4; j++)
        begin
            s4_sq_reg[j] <= (SQW'(s3_hh_reg[j]) << (2 * SL))
                          + (SQW'(s3_hl_reg[j]) << (SL + 1))
                          + SQW'(s3_ll_reg[j]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: denominator and |C|
    // ------------------------------------------------------------------
    logic [DW-1:0] s5_den_reg;
    logic [AW-1:0] s5_ac_reg;

    always_ff @(posedge clk)
    begin
        s5_den_reg <= DW'(s4_sq_reg[0]) + DW'(s4_sq_reg[1])
                    + DW'(s4_sq_reg[2]) + DW'(s4_sq_reg[3]);
        s5_ac_reg  <= AW'(s4_c_reg[CCW-1] ? CCW'(-s4_c_reg) : s4_c_reg);
    end

    // ------------------------------------------------------------------
    // Stage 6: chunk products of |C|^2
    // ------------------------------------------------------------------
    logic [MW-1:0] s6_p00_reg, s6_p11_reg, s6_p22_reg;
    logic [MW-1:0] s6_p01_reg, s6_p02_reg, s6_p12_reg;
    logic [DW-1:0] s6_den_reg;
    logic          s6_deg_reg;

    always_ff @(posedge clk)
    begin
        s6_p00_reg <= s5_ac_reg[0 +: KW] * s5_ac_reg[0 +: KW];
        s6_p11_reg <= s5_ac_reg[KW +: KW] * s5_ac_reg[KW +: KW];
        s6_p22_reg <= s5_ac_reg[2*KW +: KW] * s5_ac_reg[2*KW +: KW];
        s6_p01_reg <= s5_ac_reg[0 +: KW] * s5_ac_reg[KW +: KW];
        s6_p02_reg <= s5_ac_reg[0 +: KW] * s5_ac_reg[2*KW +: KW];
        s6_p12_reg <= s5_ac_reg[KW +: KW] * s5_ac_reg[2*KW +: KW];
        s6_den_reg <= s5_den_reg;
        s6_deg_reg <= (s5_den_reg == '0);
    end

    // ------------------------------------------------------------------
    // Stage 7: numerator C^2
    // ------------------------------------------------------------------
    logic [NW-1:0] s7_num_reg;
    logic [DW-1:0] s7_den_reg;
    logic          s7_deg_reg;

    always_ff @(posedge clk)
    begin
        s7_num_reg <= NW'(s6_p00_reg)
                    + (NW'(s6_p01_reg) << (KW + 1))
                    + (NW'(s6_p11_reg) << (2 * KW))
                    + (NW'(s6_p02_reg) << (2 * KW + 1))
                    + (NW'(s6_p12_reg) << (3 * KW + 1))
                    + (NW'(s6_p22_reg) << (4 * KW));
        s7_den_reg <= s6_den_reg;
        s7_deg_reg <= s6_deg_reg;
    end

    // ------------------------------------------------------------------
    // Divider: stage 0 holds the range check, stages 1..QW one quotient bit
    // ------------------------------------------------------------------
    logic [RW-1:0]   dv_r_reg   [QW+1];
    logic [QW-1:0]   dv_lo_reg  [QW+1];
    logic [QW-1:0]   dv_q_reg   [QW+1];
    logic [DSHW-1:0] dv_dsh_reg [QW+1];
    logic            dv_sat_reg [QW+1];
    logic            dv_deg_reg [QW+1];
    logic [QW:0]     dv_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg <= '0;
        end
        else
        begin
            dv_v_reg <= {dv_v_reg[QW-1:0], sv_reg[6]};
        end
    end

    // Saturate when C^2 >= den * 2^56; otherwise the top bits stay below den*2^8
    always_ff @(posedge clk)
    begin
        dv_sat_reg[0] <= (s7_num_reg[NW-1:QW+8] >= SATW'(s7_den_reg));
        dv_deg_reg[0] <= s7_deg_reg;
        dv_dsh_reg[0] <= {s7_den_reg, 8'b0};
        dv_r_reg[0]   <= s7_num_reg[QW +: RW];
        dv_lo_reg[0]  <= s7_num_reg[QW-1:0];
        dv_q_reg[0]   <= '0;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [RW-1:0] rs;
        logic          ge;

        always_comb
        begin
            rs = {dv_r_reg[k][RW-2:0], dv_lo_reg[k][QW-1]};
            ge = (rs >= RW'(dv_dsh_reg[k]));
        end

        always_ff @(posedge clk)
        begin
            dv_r_reg[k+1]   <= ge ? rs - RW'(dv_dsh_reg[k]) : rs;
            dv_lo_reg[k+1]  <= {dv_lo_reg[k][QW-2:0], 1'b0};
            dv_q_reg[k+1]   <= {dv_q_reg[k][QW-2:0], ge};
            dv_dsh_reg[k+1] <= dv_dsh_reg[k];
            dv_sat_reg[k+1] <= dv_sat_reg[k];
            dv_deg_reg[k+1] <= dv_deg_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Output register: degenerate wins over saturation
    // ------------------------------------------------------------------
    logic    out_v_reg;
    result_t out_reg;
    result_t out_next;

    always_comb
    begin
        out_next.degenerate = dv_deg_reg[QW];
        out_next.saturated  = dv_sat_reg[QW] & ~dv_deg_reg[QW];
        if (dv_deg_reg[QW])
        begin
            out_next.sampson_err = '0;
        end
        else if (dv_sat_reg[QW])
        begin
            out_next.sampson_err = ERR_MAX;
        end
        else
        begin
            out_next.sampson_err = dv_q_reg[QW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire
